// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/i2cbm_pkg.sv =====
// Shared types and constants of the I2C bit-level master.
package i2cbm_pkg;

    localparam logic [2:0] ACT_START    = 3'd0;
    localparam logic [2:0] ACT_STOP     = 3'd1;
    localparam logic [2:0] ACT_ACK      = 3'd2;
    localparam logic [2:0] ACT_NACK     = 3'd3;
    localparam logic [2:0] ACT_WAIT_ACK = 3'd4;
    localparam logic [2:0] ACT_WRITE    = 3'd5;
    localparam logic [2:0] ACT_READ     = 3'd6;
    localparam logic [2:0] ACT_NONE     = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY = 2'd1;
    localparam logic [1:0] ST_SDA_HIGH = 2'd2;

    typedef logic [2:0] step_t;
    localparam step_t STEP0 = 3'd0;
    localparam step_t STEP1 = 3'd1;
    localparam step_t STEP2 = 3'd2;
    localparam step_t STEP3 = 3'd3;
    localparam step_t STEP4 = 3'd4;

    localparam logic [3:0] BYTE_BITS   = 4'd8;
    localparam int         DELAY_W     = 16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd50;

    localparam logic [1:0] REG_DELAY_ADDR = 2'd0;

    // tick queue between front and back
    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    typedef struct packed {
        logic       go;          // tick carries a command that can start
        logic [2:0] action;
        logic [7:0] write_data;
        logic       sda_in;
    } tick_t;

endpackage

// ===== design/i2c_bit_level_master.sv =====
// Top level of the I2C bit-level master: config register, front queue and sequencer.
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  tdata: write_data, sda_in; tuser: cmd_valid, action
//   m_        out  m_tvalid/m_tready  tdata: scl, sda, busy, done, status, read_data, ack
//   apb       in   psel/penable       delay_ticks at byte address 0
//
// One tick item is taken per cycle while s_tready is high; its result passes through the
// tick queue and is then registered in the output register.
// The wait down-counter counts down once per tick item; the sequencer step advances when it reaches zero.
// Reset is synchronous: lines released, sequencer idle, delay_ticks back to 50.
// A stalled m_tready holds the result; the four-entry tick queue then fills and
// s_tready drops until the result is taken.
module i2c_bit_level_master import i2cbm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] sda_in
    input  logic [3:0]  s_tuser,   // [0] cmd_valid, [3:1] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
                                   // [5:4] status, [13:6] read_data, [14] ack_seen
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DELAY_W-1:0] delay_reg;
    logic               q_valid, q_ready;
    tick_t              q_tick;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DELAY_ADDR) ? {{(32-DELAY_W){1'b0}}, delay_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_DELAY_ADDR) begin
            delay_reg <= pwdata[DELAY_W-1:0];
        end
    end

    i2cbm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_tick   (q_tick)
    );

    i2cbm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .delay_ticks (delay_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_tick      (q_tick),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== design/i2cbm_front.sv =====
// Front end: accepts ticks, classifies commands, queues them for the sequencer.
module i2cbm_front import i2cbm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] sda_in
    input  logic [3:0]  s_tuser,   // [0] cmd_valid, [3:1] action
    output logic        q_valid,
    input  logic        q_ready,
    output tick_t       q_tick
);

    tick_t          entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    tick_t          in_tick;
    logic           push, pop;

    always_comb begin
        in_tick.go         = s_tuser[0] && (s_tuser[3:1] != ACT_NONE);
        in_tick.action     = s_tuser[3:1];
        in_tick.write_data = s_tdata[7:0];
        in_tick.sda_in     = s_tdata[8];
    end

    assign s_tready = (count_reg != QDEPTH[QAW:0]);
    assign q_valid  = (count_reg != '0);
    assign q_tick   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_tick;
        end
    end

endmodule

// ===== design/i2cbm_back.sv =====
// Back end: bus sequencer that plays out commands tick by tick, with output register.
module i2cbm_back import i2cbm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [DELAY_W-1:0] delay_ticks,
    input  logic               q_valid,
    output logic               q_ready,
    input  tick_t              q_tick,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata   // [0] scl_out, [1] sda_out, [2] busy_res,
                                         // [3] done_res, [5:4] status,
                                         // [13:6] read_data, [14] ack_seen
);

    logic [2:0]         act_reg, act_next;
    step_t              step_reg, step_next;
    logic [DELAY_W-1:0] wait_reg, wait_next;
    logic [3:0]         bits_reg, bits_next;
    logic [7:0]         shift_reg, shift_next;
    logic               run_reg, run_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic [1:0]         status_reg, status_next;
    logic               ack_reg, ack_next;
    logic [7:0]         rdat_reg, rdat_next;
    logic               done;

    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    logic               take, do_it;
    step_t              cur_step;
    logic [DELAY_W-1:0] dly_eff, wait_dec;

    assign q_ready = !out_valid_reg || m_tready;
    assign take    = q_valid && q_ready;
    assign dly_eff = (delay_ticks == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : delay_ticks;
    assign wait_dec = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;

    always_comb begin
        act_next    = act_reg;
        step_next   = step_reg;
        wait_next   = wait_reg;
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        run_next    = run_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        status_next = status_reg;
        ack_next    = ack_reg;
        rdat_next   = rdat_reg;
        done        = 1'b0;
        do_it       = 1'b0;
        cur_step    = step_reg;

        if (take) begin
            if (run_reg) begin
                wait_next = wait_dec;
                do_it     = (wait_dec == '0);
            end else if (q_tick.go) begin
                run_next   = 1'b1;
                act_next   = q_tick.action;
                cur_step   = STEP0;
                bits_next  = (q_tick.action == ACT_WRITE || q_tick.action == ACT_READ)
                             ? BYTE_BITS : 4'd0;
                shift_next = (q_tick.action == ACT_WRITE) ? q_tick.write_data : 8'd0;
                do_it      = 1'b1;
            end
        end

        if (do_it) begin
            unique case (act_next)
                ACT_START: begin
                    if (cur_step == STEP0) begin
                        sda_next = 1'b1; scl_next = 1'b1;
                        wait_next = dly_eff; step_next = STEP1;
                    end else if (cur_step == STEP1) begin
                        if (!q_tick.sda_in) begin
                            run_next = 1'b0; done = 1'b1; status_next = ST_BUS_BUSY;
                            step_next = STEP0; wait_next = '0;
                        end else begin
                            sda_next = 1'b0;
                            wait_next = dly_eff; step_next = STEP2;
                        end
                    end else if (cur_step == STEP2) begin
                        if (q_tick.sda_in) begin
                            run_next = 1'b0; done = 1'b1; status_next = ST_SDA_HIGH;
                            step_next = STEP0; wait_next = '0;
                        end else begin
                            scl_next = 1'b0;
                            wait_next = dly_eff; step_next = STEP3;
                        end
                    end else begin
                        run_next = 1'b0; done = 1'b1; status_next = ST_OK;
                        step_next = STEP0; wait_next = '0;
                    end
                end
                ACT_STOP: begin
                    if (cur_step == STEP0) begin
                        scl_next = 1'b0; wait_next = dly_eff; step_next = STEP1;
                    end else if (cur_step == STEP1) begin
                        sda_next = 1'b0; wait_next = dly_eff; step_next = STEP2;
                    end else if (cur_step == STEP2) begin
                        scl_next = 1'b1; wait_next = dly_eff; step_next = STEP3;
                    end else if (cur_step == STEP3) begin
                        sda_next = 1'b1; wait_next = dly_eff; step_next = STEP4;
                    end else begin
                        run_next = 1'b0; done = 1'b1; status_next = ST_OK;
                        step_next = STEP0; wait_next = '0;
                    end
                end
                ACT_ACK, ACT_NACK: begin
                    if (cur_step == STEP0) begin
                        scl_next = 1'b0; wait_next = dly_eff; step_next = STEP1;
                    end else if (cur_step == STEP1) begin
                        sda_next = (act_next == ACT_NACK);
                        wait_next = dly_eff; step_next = STEP2;
                    end else if (cur_step == STEP2) begin
                        scl_next = 1'b1; wait_next = dly_eff; step_next = STEP3;
                    end else if (cur_step == STEP3) begin
                        scl_next = 1'b0; wait_next = dly_eff; step_next = STEP4;
                    end else begin
                        run_next = 1'b0; done = 1'b1; status_next = ST_OK;
                        step_next = STEP0; wait_next = '0;
                    end
                end
                ACT_WAIT_ACK: begin
                    if (cur_step == STEP0) begin
                        scl_next = 1'b0; wait_next = dly_eff; step_next = STEP1;
                    end else if (cur_step == STEP1) begin
                        sda_next = 1'b1; wait_next = dly_eff; step_next = STEP2;
                    end else if (cur_step == STEP2) begin
                        scl_next = 1'b1; wait_next = dly_eff; step_next = STEP3;
                    end else begin
                        ack_next = !q_tick.sda_in; scl_next = 1'b0;
                        run_next = 1'b0; done = 1'b1; status_next = ST_OK;
                        step_next = STEP0; wait_next = '0;
                    end
                end
                ACT_WRITE: begin
                    if (cur_step == STEP0) begin
                        scl_next = 1'b0; wait_next = dly_eff; step_next = STEP1;
                    end else if (cur_step == STEP1) begin
                        sda_next   = shift_next[7];
                        shift_next = {shift_next[6:0], 1'b0};
                        wait_next  = dly_eff; step_next = STEP2;
                    end else if (cur_step == STEP2) begin
                        scl_next = 1'b1;
                        if (bits_next != 4'd0) bits_next = bits_next - 4'd1;
                        wait_next = dly_eff; step_next = STEP3;
                    end else begin
                        scl_next = 1'b0;
                        if (bits_next != 4'd0) begin
                            wait_next = dly_eff; step_next = STEP1;
                        end else begin
                            run_next = 1'b0; done = 1'b1; status_next = ST_OK;
                            step_next = STEP0; wait_next = '0;
                        end
                    end
                end
                default: begin
                    // read byte
                    if (cur_step == STEP0) begin
                        sda_next = 1'b1; scl_next = 1'b0;
                        wait_next = dly_eff; step_next = STEP1;
                    end else if (cur_step == STEP1) begin
                        scl_next = 1'b1; wait_next = dly_eff; step_next = STEP2;
                    end else begin
                        shift_next = {shift_next[6:0], q_tick.sda_in};
                        if (bits_next != 4'd0) bits_next = bits_next - 4'd1;
                        scl_next = 1'b0;
                        if (bits_next != 4'd0) begin
                            wait_next = dly_eff; step_next = STEP1;
                        end else begin
                            rdat_next = shift_next;
                            run_next = 1'b0; done = 1'b1; status_next = ST_OK;
                            step_next = STEP0; wait_next = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= ACT_START;
            step_reg      <= STEP0;
            wait_reg      <= '0;
            bits_reg      <= '0;
            shift_reg     <= '0;
            run_reg       <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            status_reg    <= ST_OK;
            ack_reg       <= 1'b0;
            rdat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            act_reg    <= act_next;
            step_reg   <= step_next;
            wait_reg   <= wait_next;
            bits_reg   <= bits_next;
            shift_reg  <= shift_next;
            run_reg    <= run_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            status_reg <= status_next;
            ack_reg    <= ack_next;
            rdat_reg   <= rdat_next;
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= {1'b0, ack_next, rdat_next, status_next,
                             done, run_next, sda_next, scl_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/i2cbm_checker.sv =====
// Port-level checks of the I2C bit-level master, bound to the top level.
`include "assert_macros.svh"

module i2cbm_checker import i2cbm_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a finishing tick never reports the sequencer still busy
    `ASSERT_CLK(a_done_not_busy, aclk, aresetn, m_tvalid && m_tdata[3] |-> !m_tdata[2], "done with busy set")
    `ASSERT_CLK(a_status_code, aclk, aresetn, m_tvalid |-> m_tdata[5:4] != 2'b11, "bad status code")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result after reset")
    `ASSERT_CLK_ALWAYS(a_reset_ready, aclk, !aresetn |=> s_tready, "input not ready after reset")

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/i2c_bit_level_master_test.sv =====
// Self-checking testbench for the I2C bit-level master: streamed ticks, predicted line levels.
`timescale 1ns / 1ps

module i2c_bit_level_master_test;
    import i2cbm_pkg::*;

    typedef struct packed {
        logic [15:0] delay;
        logic [2:0]  act;
        step_t       step;
        logic [15:0] wait_cnt;
        logic [3:0]  bits_left;
        logic [7:0]  shreg;
        logic        running;
        logic        scl;
        logic        sda;
        logic [1:0]  status;
        logic        ack;
        logic [7:0]  rdata;
        logic        done;
    } master_state_t;

    // m_tdata layout, lowest bit last
    typedef struct packed {
        logic       pad;
        logic       ack;
        logic [7:0] rdata;
        logic [1:0] status;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } line_out_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] action;
        logic [7:0] wdata;
        logic       sda;
    } tick_in_t;

    // how the far end drives SDA while a command runs
    typedef enum logic [1:0] {BUS_FOLLOW, BUS_LOW, BUS_HIGH} slave_drive_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tick_in_t      tick_queue[$];
    line_out_t     due_outputs[$];
    master_state_t bus_model;
    master_state_t stim_model;
    tick_in_t      next_tick;
    line_out_t     want;
    line_out_t     got;
    int            send_idle_pct = 17;
    int            recv_idle_pct = 64;
    int            fail_count = 0;
    int            ticks_made = 0;

    i2c_bit_level_master uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] write_data, [8] sda_in
        .s_tuser  (s_tuser),   // [0] cmd_valid, [3:1] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [0] scl, [1] sda, [2] busy, [3] done, [5:4] status,
                               // [13:6] read_data, [14] ack_seen
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic master_state_t arm_wait(master_state_t m, step_t nxt);
        m.wait_cnt = (m.delay == 16'd0) ? 16'd1 : m.delay;
        m.step = nxt;
        return m;
    endfunction

    function automatic master_state_t end_cmd(master_state_t m, logic [1:0] st);
        m.running = 1'b0;
        m.done = 1'b1;
        m.status = st;
        m.step = STEP0;
        m.wait_cnt = 16'd0;
        return m;
    endfunction

    function automatic master_state_t seq_step(master_state_t m, logic sda);
        case (m.act)
            ACT_START: begin
                case (m.step)
                    STEP0: begin
                        m.sda = 1'b1;
                        m.scl = 1'b1;
                        m = arm_wait(m, STEP1);
                    end
                    STEP1: begin
                        if (!sda) begin
                            m = end_cmd(m, ST_BUS_BUSY);
                        end else begin
                            m.sda = 1'b0;
                            m = arm_wait(m, STEP2);
                        end
                    end
                    STEP2: begin
                        if (sda) begin
                            m = end_cmd(m, ST_SDA_HIGH);
                        end else begin
                            m.scl = 1'b0;
                            m = arm_wait(m, STEP3);
                        end
                    end
                    default: m = end_cmd(m, ST_OK);
                endcase
            end
            ACT_STOP: begin
                case (m.step)
                    STEP0: begin m.scl = 1'b0; m = arm_wait(m, STEP1); end
                    STEP1: begin m.sda = 1'b0; m = arm_wait(m, STEP2); end
                    STEP2: begin m.scl = 1'b1; m = arm_wait(m, STEP3); end
                    STEP3: begin m.sda = 1'b1; m = arm_wait(m, STEP4); end
                    default: m = end_cmd(m, ST_OK);
                endcase
            end
            ACT_ACK, ACT_NACK: begin
                case (m.step)
                    STEP0: begin m.scl = 1'b0; m = arm_wait(m, STEP1); end
                    STEP1: begin m.sda = (m.act == ACT_NACK); m = arm_wait(m, STEP2); end
                    STEP2: begin m.scl = 1'b1; m = arm_wait(m, STEP3); end
                    STEP3: begin m.scl = 1'b0; m = arm_wait(m, STEP4); end
                    default: m = end_cmd(m, ST_OK);
                endcase
            end
            ACT_WAIT_ACK: begin
                case (m.step)
                    STEP0: begin m.scl = 1'b0; m = arm_wait(m, STEP1); end
                    STEP1: begin m.sda = 1'b1; m = arm_wait(m, STEP2); end
                    STEP2: begin m.scl = 1'b1; m = arm_wait(m, STEP3); end
                    default: begin
                        m.ack = !sda;
                        m.scl = 1'b0;
                        m = end_cmd(m, ST_OK);
                    end
                endcase
            end
            ACT_WRITE: begin
                case (m.step)
                    STEP0: begin m.scl = 1'b0; m = arm_wait(m, STEP1); end
                    STEP1: begin
                        m.sda = m.shreg[7];
                        m.shreg = {m.shreg[6:0], 1'b0};
                        m = arm_wait(m, STEP2);
                    end
                    STEP2: begin
                        m.scl = 1'b1;
                        if (m.bits_left != 4'd0) m.bits_left = m.bits_left - 4'd1;
                        m = arm_wait(m, STEP3);
                    end
                    default: begin
                        m.scl = 1'b0;
                        if (m.bits_left != 4'd0) m = arm_wait(m, STEP1);
                        else m = end_cmd(m, ST_OK);
                    end
                endcase
            end
            default: begin
                case (m.step)
                    STEP0: begin
                        m.sda = 1'b1;
                        m.scl = 1'b0;
                        m = arm_wait(m, STEP1);
                    end
                    STEP1: begin m.scl = 1'b1; m = arm_wait(m, STEP2); end
                    default: begin
                        m.shreg = {m.shreg[6:0], sda};
                        if (m.bits_left != 4'd0) m.bits_left = m.bits_left - 4'd1;
                        m.scl = 1'b0;
                        if (m.bits_left != 4'd0) begin
                            m = arm_wait(m, STEP1);
                        end else begin
                            m.rdata = m.shreg;
                            m = end_cmd(m, ST_OK);
                        end
                    end
                endcase
            end
        endcase
        return m;
    endfunction

    // one tick of the master: count down the wait, or start a new command
    function automatic master_state_t i2c_advance(master_state_t m, logic valid,
                                                  logic [2:0] act, logic [7:0] wdat,
                                                  logic sda);
        m.done = 1'b0;
        if (m.running) begin
            if (m.wait_cnt != 16'd0) m.wait_cnt = m.wait_cnt - 16'd1;
            if (m.wait_cnt == 16'd0) m = seq_step(m, sda);
        end else if (valid && act != ACT_NONE) begin
            m.running = 1'b1;
            m.act = act;
            m.step = STEP0;
            m.bits_left = (act == ACT_WRITE || act == ACT_READ) ? BYTE_BITS : 4'd0;
            m.shreg = (act == ACT_WRITE) ? wdat : 8'd0;
            m = seq_step(m, sda);
        end
        return m;
    endfunction

    // driver: predicts each accepted tick, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                bus_model = i2c_advance(bus_model, s_tuser[0], s_tuser[3:1],
                                        s_tdata[7:0], s_tdata[8]);
                due_outputs.push_back('{1'b0, bus_model.ack, bus_model.rdata,
                                        bus_model.status, bus_model.done,
                                        bus_model.running, bus_model.sda,
                                        bus_model.scl});
            end
            if (!s_tvalid || s_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_tick = tick_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, next_tick.sda, next_tick.wdata};
                    s_tuser <= {next_tick.action, next_tick.cmd_valid};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic field_check(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // monitor: compares each result item with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_outputs.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                end else begin
                    want = due_outputs.pop_front();
                    field_check("scl_out", int'(want.scl), int'(got.scl));
                    field_check("sda_out", int'(want.sda), int'(got.sda));
                    field_check("busy_res", int'(want.busy), int'(got.busy));
                    field_check("done_res", int'(want.done), int'(got.done));
                    field_check("status", int'(want.status), int'(got.status));
                    field_check("read_data", int'(want.rdata), int'(got.rdata));
                    field_check("ack_seen", int'(want.ack), int'(got.ack));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= REG_DELAY_ADDR;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_delay_reg(input logic [15:0] exp_v);
        logic [31:0] rd;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== {16'd0, exp_v}) begin
            fail_count++;
            $display("%0t: delay_ticks readback, expected %0d, got %0d", $time, exp_v, rd);
        end
    endtask

    task automatic set_delay(input logic [15:0] v);
        logic [31:0] rd;
        apb_xfer(1'b1, {16'd0, v}, rd);
        bus_model.delay = v;
        stim_model.delay = v;
        check_delay_reg(v);
    endtask

    // builds one tick; SDA mostly follows what a real bus would show
    task automatic gen_tick(input logic v, input logic [2:0] a, input logic [7:0] d,
                            input slave_drive_t drv);
        logic     sda_bit;
        tick_in_t t;
        case (drv)
            BUS_LOW:  sda_bit = 1'b0;
            BUS_HIGH: sda_bit = 1'b1;
            default: begin
                if ($urandom_range(0, 9) == 0) sda_bit = 1'($urandom_range(0, 1));
                else if (!stim_model.sda) sda_bit = 1'b0;
                else if (stim_model.running && stim_model.act == ACT_START)
                    sda_bit = ($urandom_range(0, 7) != 0);
                else sda_bit = 1'($urandom_range(0, 1));
            end
        endcase
        t = '{v, a, d, sda_bit};
        tick_queue.push_back(t);
        stim_model = i2c_advance(stim_model, v, a, d, sda_bit);
        ticks_made++;
    endtask

    // one command played to its end; stray commands land while busy
    task automatic run_cmd(input logic [2:0] a, input logic [7:0] d, input slave_drive_t drv);
        gen_tick(1'b1, a, d, drv);
        while (stim_model.running)
            gen_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), drv);
        repeat ($urandom_range(1, 3))
            gen_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), drv);
    endtask

    task automatic run_random(input int budget);
        int start_cnt;
        logic v;
        start_cnt = ticks_made;
        while (ticks_made - start_cnt < budget) begin
            if (!stim_model.running) v = ($urandom_range(0, 3) != 0);
            else v = ($urandom_range(0, 7) == 0);
            gen_tick(v, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), BUS_FOLLOW);
        end
        while (stim_model.running)
            gen_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                     BUS_FOLLOW);
    endtask

    // wait until every tick is taken and every result is back
    task automatic quiesce;
        while (tick_queue.size() != 0 || due_outputs.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        bus_model = '0;
        bus_model.delay = DELAY_RESET;
        bus_model.scl = 1'b1;
        bus_model.sda = 1'b1;
        stim_model = bus_model;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_delay_reg(DELAY_RESET);

        set_delay(16'd1);
        run_cmd(ACT_START, 8'h00, BUS_FOLLOW);
        run_cmd(ACT_START, 8'h00, BUS_LOW);      // bus held low: busy
        run_cmd(ACT_START, 8'h00, BUS_HIGH);     // SDA never goes low
        run_cmd(ACT_WRITE, 8'h00, BUS_FOLLOW);
        run_cmd(ACT_WRITE, 8'hFF, BUS_FOLLOW);
        run_cmd(ACT_WRITE, 8'hA5, BUS_FOLLOW);
        run_cmd(ACT_WAIT_ACK, 8'h00, BUS_LOW);
        run_cmd(ACT_WAIT_ACK, 8'h00, BUS_HIGH);
        run_cmd(ACT_READ, 8'h00, BUS_HIGH);
        run_cmd(ACT_READ, 8'hFF, BUS_LOW);
        run_cmd(ACT_READ, 8'h00, BUS_FOLLOW);
        run_cmd(ACT_ACK, 8'h00, BUS_FOLLOW);
        run_cmd(ACT_NACK, 8'h00, BUS_FOLLOW);
        run_cmd(ACT_NONE, 8'h3C, BUS_FOLLOW);
        run_cmd(ACT_STOP, 8'h00, BUS_FOLLOW);
        quiesce();

        set_delay(16'd0);
        run_random(100);
        quiesce();

        set_delay(16'd2);
        run_random(300);
        quiesce();

        send_idle_pct = 64;
        recv_idle_pct = 17;
        set_delay(16'd1);
        run_random(300);
        quiesce();

        set_delay(16'd3);
        run_random(200);
        quiesce();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_delay(16'd255);
        run_cmd(ACT_START, 8'h00, BUS_LOW);
        quiesce();

        // widest delay value: register path only
        set_delay(16'hFFFF);

        set_delay(16'd1);
        run_random(100);
        quiesce();

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
